/* rtl/efws_pkg.sv */
// Shared types and constants for the earliest-free worker scheduler.
`timescale 1ns / 1ps

package efws_pkg;

	localparam int MAX_WORKERS   = 16;
	localparam int TIME_BITS     = 48;
	localparam int IDX_BITS      = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int CNT_BITS      = $clog2(MAX_WORKERS + 1);
	localparam int CHILD_BITS    = IDX_BITS + 2;
	localparam int CFG_BITS      = 5;
	localparam int DUR_BITS      = 32;
	localparam int WORKER_BITS   = 4;
	localparam int START_BITS    = 48;
	localparam int RESET_WORKERS = (2 > MAX_WORKERS) ? MAX_WORKERS : 2;

	typedef struct packed {
		logic [TIME_BITS-1:0] ftime;
		logic [IDX_BITS-1:0]  id;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LVL,
		S_CMPL,
		S_CMPR
	} state_t;

endpackage

/* rtl/efws_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module efws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/efws_cmp.sv */
// Shared heap-order comparator: earlier free time first, then lower worker index.
`timescale 1ns / 1ps

module efws_cmp (
	input  efws_pkg::entry_t a,
	input  efws_pkg::entry_t b,
	output logic             earlier
);

	assign earlier = (a.ftime < b.ftime) || ((a.ftime == b.ftime) && (a.id < b.id));

endmodule

/* rtl/earliest_free_worker_scheduler.sv */
// Top level of the earliest-free worker scheduler: heap sequencer and handshakes.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   job_duration[31:0]
// out      output     out_valid / out_stall assigned_worker[3:0], start_time[47:0]
// cfg      input      cfg_valid / cfg_ready cfg_data[4:0] (worker_count)
//
// The result of a request comes from the cached heap root. The sift-down then
// visits S_LVL, S_CMPL and S_CMPR at a level with two children, S_LVL and
// S_CMPL with one child and S_LVL alone at the bottom, a sequence set by the
// single comparator and the one-read-port heap RAM.
// No new request is taken during the sift or while a held result is stalled.
// Reset and a worker_count write rebuild the heap at once through valid bits.
`timescale 1ns / 1ps

module earliest_free_worker_scheduler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [efws_pkg::DUR_BITS-1:0]        job_duration,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [efws_pkg::WORKER_BITS-1:0]     assigned_worker,
	output logic [efws_pkg::START_BITS-1:0]      start_time,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [efws_pkg::CFG_BITS-1:0]        cfg_data
);

	efws_pkg::state_t                         state_q, state_d;
	logic [efws_pkg::IDX_BITS-1:0]            pos_q, pos_d;
	efws_pkg::entry_t                         cur_q;
	efws_pkg::entry_t                         best_q, best_d;
	logic                                     best_child_q, best_child_d;
	efws_pkg::entry_t                         root_q;
	logic [efws_pkg::CNT_BITS-1:0]            n_q;
	logic [efws_pkg::MAX_WORKERS-1:0]         valid_q;
	logic                                     rd_valid_s1;
	logic [efws_pkg::IDX_BITS-1:0]            rd_addr_s1;
	logic                                     out_valid_q;
	logic [efws_pkg::WORKER_BITS-1:0]         out_id_q;
	logic [efws_pkg::START_BITS-1:0]          out_start_q;

	logic                                     in_acc;
	logic                                     cfg_acc;
	logic                                     ram_we;
	logic [efws_pkg::IDX_BITS-1:0]            waddr;
	efws_pkg::entry_t                         wdata;
	logic [efws_pkg::IDX_BITS-1:0]            raddr;
	logic [efws_pkg::ENTRY_BITS-1:0]          ram_rdata;
	efws_pkg::entry_t                         rd_entry;
	efws_pkg::entry_t                         cmp_b;
	logic                                     earlier;
	logic [efws_pkg::CHILD_BITS-1:0]          left;
	logic [efws_pkg::CHILD_BITS-1:0]          right;
	logic [efws_pkg::CHILD_BITS-1:0]          n_ext;
	logic [efws_pkg::TIME_BITS:0]             sum;
	logic [efws_pkg::TIME_BITS-1:0]           sat_time;

	assign cfg_ready = (state_q == efws_pkg::S_IDLE);
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_stall  = !((state_q == efws_pkg::S_IDLE) && !cfg_valid &&
		(!out_valid_q || !out_stall));
	assign in_acc    = in_valid && !in_stall;

	assign out_valid       = out_valid_q;
	assign assigned_worker = out_id_q;
	assign start_time      = out_start_q;

	assign sum      = {1'b0, root_q.ftime} + (efws_pkg::TIME_BITS + 1)'(job_duration);
	assign sat_time = sum[efws_pkg::TIME_BITS] ? '1 : sum[efws_pkg::TIME_BITS-1:0];

	assign left  = efws_pkg::CHILD_BITS'({pos_q, 1'b1});
	assign right = left + efws_pkg::CHILD_BITS'(1);
	assign n_ext = efws_pkg::CHILD_BITS'(n_q);

	always_comb begin
		rd_entry = efws_pkg::entry_t'(ram_rdata);
		if (!rd_valid_s1) begin
			rd_entry.ftime = '0;
			rd_entry.id    = rd_addr_s1;
		end
	end

	assign cmp_b = (state_q == efws_pkg::S_CMPL) ? cur_q : best_q;

	efws_cmp u_cmp (
		.a       (rd_entry),
		.b       (cmp_b),
		.earlier (earlier)
	);

	efws_ram #(
		.WIDTH (efws_pkg::ENTRY_BITS),
		.DEPTH (efws_pkg::MAX_WORKERS)
	) u_heap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d      = state_q;
		pos_d        = pos_q;
		best_d       = best_q;
		best_child_d = best_child_q;
		ram_we       = 1'b0;
		waddr        = pos_q;
		wdata        = cur_q;
		raddr        = left[efws_pkg::IDX_BITS-1:0];
		case (state_q)
			efws_pkg::S_IDLE: begin
				if (in_acc) begin
					pos_d   = '0;
					state_d = efws_pkg::S_LVL;
				end
			end
			efws_pkg::S_LVL: begin
				if (left < n_ext) begin
					state_d = efws_pkg::S_CMPL;
				end else begin
					ram_we  = 1'b1;
					state_d = efws_pkg::S_IDLE;
				end
			end
			efws_pkg::S_CMPL: begin
				best_child_d = earlier;
				best_d       = earlier ? rd_entry : cur_q;
				if (right < n_ext) begin
					raddr   = right[efws_pkg::IDX_BITS-1:0];
					state_d = efws_pkg::S_CMPR;
				end else if (earlier) begin
					ram_we  = 1'b1;
					wdata   = rd_entry;
					pos_d   = left[efws_pkg::IDX_BITS-1:0];
					state_d = efws_pkg::S_LVL;
				end else begin
					ram_we  = 1'b1;
					state_d = efws_pkg::S_IDLE;
				end
			end
			efws_pkg::S_CMPR: begin
				if (earlier) begin
					ram_we  = 1'b1;
					wdata   = rd_entry;
					pos_d   = right[efws_pkg::IDX_BITS-1:0];
					state_d = efws_pkg::S_LVL;
				end else if (best_child_q) begin
					ram_we  = 1'b1;
					wdata   = best_q;
					pos_d   = left[efws_pkg::IDX_BITS-1:0];
					state_d = efws_pkg::S_LVL;
				end else begin
					ram_we  = 1'b1;
					state_d = efws_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = efws_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efws_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q          <= efws_pkg::CNT_BITS'(efws_pkg::RESET_WORKERS);
			valid_q      <= '0;
			root_q       <= '0;
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
			pos_q        <= '0;
			best_child_q <= 1'b0;
		end else begin
			rd_valid_s1  <= valid_q[raddr];
			pos_q        <= pos_d;
			best_child_q <= best_child_d;
			if (cfg_acc) begin
				if (cfg_data == '0) begin
					n_q <= efws_pkg::CNT_BITS'(1);
				end else if (32'(cfg_data) > efws_pkg::MAX_WORKERS) begin
					n_q <= efws_pkg::CNT_BITS'(efws_pkg::MAX_WORKERS);
				end else begin
					n_q <= efws_pkg::CNT_BITS'(cfg_data);
				end
				valid_q <= '0;
				root_q  <= '0;
			end else if (ram_we) begin
				valid_q[waddr] <= 1'b1;
				if (waddr == '0) begin
					root_q <= wdata;
				end
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= raddr;
		best_q     <= best_d;
		if (in_acc) begin
			out_id_q    <= efws_pkg::WORKER_BITS'(root_q.id);
			out_start_q <= efws_pkg::START_BITS'(root_q.ftime);
			cur_q.ftime <= sat_time;
			cur_q.id    <= root_q.id;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted request did not produce a result");

	a_write_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != efws_pkg::S_IDLE))
		else $error("heap written while idle");

	a_pos_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != efws_pkg::S_IDLE) |-> (efws_pkg::CHILD_BITS'(pos_q) < n_ext))
		else $error("sift position beyond heap size");

	a_root_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (waddr == '0) && !cfg_acc) |=> (root_q == $past(wdata)))
		else $error("cached root does not match heap entry zero");
`endif

endmodule

/* verif/efws_scoreboard_pkg.sv */
// Scoreboard class that predicts and checks worker assignments of the scheduler.
`timescale 1ns / 1ps

package efws_scoreboard_pkg;

	import efws_pkg::*;

	typedef struct packed {
		logic [WORKER_BITS-1:0] worker;
		logic [START_BITS-1:0]  start;
	} assignment_t;

	class efws_scoreboard;

		entry_t        heap[MAX_WORKERS];
		int unsigned   heap_size;
		assignment_t   pending_assignments[$];
		int unsigned   mismatches;

		function new();
			mismatches = 0;
			restart(CFG_BITS'(RESET_WORKERS));
		endfunction

		function void restart(input logic [CFG_BITS-1:0] count);
			if (count == 0)
				heap_size = 1;
			else if (count > MAX_WORKERS)
				heap_size = MAX_WORKERS;
			else
				heap_size = 32'(count);
			for (int k = 0; k < MAX_WORKERS; k++) begin
				heap[k].ftime = '0;
				heap[k].id    = IDX_BITS'(k);
			end
		endfunction

		function void sift_root_down();
			int unsigned pos;
			int unsigned left;
			int unsigned right;
			int unsigned best;
			bit          done;
			entry_t      tmp;
			pos  = 0;
			done = 0;
			while (!done) begin
				left  = 2 * pos + 1;
				right = left + 1;
				best  = pos;
				if (left < heap_size && heap[left] < heap[best])
					best = left;
				if (right < heap_size && heap[right] < heap[best])
					best = right;
				if (best == pos) begin
					done = 1;
				end else begin
					tmp        = heap[pos];
					heap[pos]  = heap[best];
					heap[best] = tmp;
					pos        = best;
				end
			end
		endfunction

		function assignment_t predict_assignment(input logic [DUR_BITS-1:0] duration);
			assignment_t          result;
			logic [TIME_BITS:0]   sum;
			result.worker = WORKER_BITS'(heap[0].id);
			result.start  = START_BITS'(heap[0].ftime);
			sum = {1'b0, heap[0].ftime} + (TIME_BITS + 1)'(duration);
			heap[0].ftime = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
			sift_root_down();
			return result;
		endfunction

		function void note_job(input logic [DUR_BITS-1:0] duration);
			pending_assignments.push_back(predict_assignment(duration));
		endfunction

		task report_mismatch(input string msg);
			mismatches++;
			if (mismatches <= 100)
				$display("MISMATCH at %0t: %s", $time, msg);
		endtask

		task check_assignment(input logic [WORKER_BITS-1:0] worker,
				input logic [START_BITS-1:0] start);
			assignment_t exp;
			if (pending_assignments.size() == 0) begin
				report_mismatch($sformatf("result worker=%0d start=%0d with no request pending",
					worker, start));
			end else begin
				exp = pending_assignments.pop_front();
				if (worker !== exp.worker)
					report_mismatch($sformatf("assigned_worker got %0d, expected %0d",
						worker, exp.worker));
				if (start !== exp.start)
					report_mismatch($sformatf("start_time got %0d, expected %0d",
						start, exp.start));
			end
		endtask

		function int unsigned pending();
			return pending_assignments.size();
		endfunction

	endclass

endpackage

/* verif/tb_top.sv */
// Top-level testbench of the earliest-free worker scheduler.
`timescale 1ns / 1ps

module tb_top;

	import efws_pkg::*;
	import efws_scoreboard_pkg::*;

	localparam int          SETTLE_CYCLES = 24;
	localparam int          PHASES        = 12;
	localparam int          PHASE_JOBS    = 105;
	localparam int          SAT_JOBS      = 24;
	localparam longint      TIMEOUT_NS    = 64'd40_000_000;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [DUR_BITS-1:0]    job_duration;
	logic                   out_valid;
	logic                   out_stall;
	logic [WORKER_BITS-1:0] assigned_worker;
	logic [START_BITS-1:0]  start_time;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_BITS-1:0]    cfg_data;

	bit                     idle_en;
	bit                     hold_req;
	int unsigned            hold_cycles;
	efws_scoreboard         sb;

	earliest_free_worker_scheduler dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.job_duration    (job_duration),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.assigned_worker (assigned_worker),
		.start_time      (start_time),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL earliest_free_worker_scheduler");
		$finish;
	end

	function automatic int unsigned idle_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(12, 48);
	endfunction

	function automatic logic [DUR_BITS-1:0] random_duration();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return $urandom_range(0, 15);
			4, 5, 6: return $urandom_range(0, 5000);
			default: return $urandom();
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_job(job_duration);
			if (out_valid && !out_stall)
				sb.check_assignment(assigned_worker, start_time);
			if (cfg_valid && cfg_ready)
				sb.restart(cfg_data);
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (hold_cycles) @(negedge clk);
				out_stall <= 1'b0;
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat (idle_cycles()) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_job(input logic [DUR_BITS-1:0] duration);
		int unsigned gap;
		gap = (idle_en && $urandom_range(0, 2) == 0) ? idle_cycles() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		job_duration <= duration;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic stop_jobs();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_for_drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_worker_count(input logic [CFG_BITS-1:0] count);
		stop_jobs();
		wait_for_drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= count;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [CFG_BITS-1:0] phase_counts[PHASES];
		in_valid     = 1'b0;
		job_duration = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		arst_n       = 1'b0;
		idle_en      = 1'b0;
		hold_req     = 1'b0;
		hold_cycles  = 0;
		sb = new();
		phase_counts = '{5'd16, 5'd17, 5'd1, 5'd2, 5'd5, 5'd31, 5'd9, 5'd16, 5'd3, 5'd0,
			5'd0, 5'd0};
		phase_counts[10] = CFG_BITS'($urandom_range(0, 31));
		phase_counts[11] = CFG_BITS'($urandom_range(0, 31));
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset worker count, extremes of the duration
		idle_en = 1'b1;
		send_job('0);
		send_job('1);
		send_job('0);
		send_job(32'd1);
		send_job(32'h8000_0000);
		send_job(32'd3);

		// zero count taken as one worker
		write_worker_count('0);
		send_job(32'd10);
		send_job('0);
		send_job('1);

		// oversize count taken as all workers; equal times break on index
		write_worker_count('1);
		for (int k = 0; k < MAX_WORKERS; k++)
			send_job('0);

		for (int p = 0; p < PHASES; p++) begin
			write_worker_count(phase_counts[p]);
			idle_en = (p % 4 != 3);
			if (p == 2) begin
				hold_cycles = 400;
				hold_req    = 1'b1;
			end
			for (int j = 0; j < PHASE_JOBS; j++)
				send_job(random_duration());
		end

		// back-to-back maximum durations on one worker
		write_worker_count(5'd1);
		idle_en = 1'b0;
		for (int j = 0; j < SAT_JOBS; j++)
			send_job('1);
		send_job('0);

		stop_jobs();
		wait_for_drain();
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
		if (sb.mismatches == 0)
			$display("PASS earliest_free_worker_scheduler");
		else
			$display("FAIL earliest_free_worker_scheduler");
		$finish;
	end

endmodule
